[hdl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_TOTAL = COLUMNS * ROWS;
   localparam int SCROLL_LIM = COLUMNS * (ROWS - 1);

   // field widths fixed by the interface
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int CUR_W  = 11;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   localparam int ADDR_W = $clog2(CELL_TOTAL);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CELL_W-1:0] CELL_RESET     = 16'h0F20;

   localparam logic [2:0] KIND_PUT       = 3'd0;
   localparam logic [2:0] KIND_NEWLINE   = 3'd1;
   localparam logic [2:0] KIND_BACKSPACE = 3'd2;
   localparam logic [2:0] KIND_READ      = 3'd3;
   localparam logic [2:0] KIND_CLEAR     = 3'd4;
   localparam logic [2:0] KIND_NOP       = 3'd5;

   typedef struct packed {
      logic [2:0]        kind;
      logic [CHAR_W-1:0] char_code;
      logic [CUR_W-1:0]  cell_index;
   } tcw_cmd_type;

   // back end to front end
   typedef struct packed {
      logic pop;
      logic busy;
   } tcw_status_type;

endpackage

[hdl/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit
// 80x25 text console: screen memory, cursor and colour registers.
// ----------------------------------------------------------------------------
// After reset the unit fills the screen with white spaces on black, one cell
// a cycle, with req_tready low; colour writes are taken at any time.
// Requests pass a two-entry command queue to the execution unit, which
// owns the single-port-write screen memory. A character, newline, backspace,
// out-of-range read or unused op is retired straight from idle; an in-range
// read passes the registered memory read and then the emit state. A write
// that lands past the last cell first scrolls: it copies each cell up one
// row, writes the last copied cell, then fills the bottom row, with one read
// and one write of the memory per cycle. A clear fills every cell and then
// sends the reply from the emit state.
// ----------------------------------------------------------------------------
module text_console_writer_unit
   import tcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,   // [1:0] op, [9:2] char_code, [20:10] cell_index
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // [15:0] cell_data, [26:16] cursor_pos
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [3:0]    csr_wdata
);

   localparam logic CSR_FORE = 1'b0;
   localparam logic CSR_BACK = 1'b1;

   logic [3:0]     fore_ff, fore_in;
   logic [3:0]     back_ff, back_in;
   logic           head_valid;
   tcw_cmd_type    head_cmd;
   tcw_status_type status;

   always_comb begin
      fore_in = fore_ff;
      back_in = back_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FORE: fore_in = csr_wdata;
            CSR_BACK: back_in = csr_wdata;
            default:  fore_in = fore_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fore_ff <= 4'd15;
         back_ff <= 4'd0;
      end else begin
         fore_ff <= fore_in;
         back_ff <= back_in;
      end
   end

   tcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .status     (status),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .attr       ({back_ff, fore_ff}),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hdl/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request beats, decodes them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tcw_front
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // op, char_code, cell_index
   input  tcw_status_type        status,
   output logic                  head_valid,
   output tcw_cmd_type           head_cmd
);

   tcw_cmd_type      queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic [OP_W-1:0]  op;
   logic [CHAR_W-1:0] char_code;
   logic [CUR_W-1:0] cell_index;
   tcw_cmd_type      cmd;

   assign op         = req_tdata[1:0];
   assign char_code  = req_tdata[9:2];
   assign cell_index = req_tdata[20:10];

   assign req_tready = (count_ff != 2'd2) && !status.busy;
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      cmd.char_code  = char_code;
      cmd.cell_index = cell_index;
      case (op)
         OP_WRITE: begin
            if (char_code == CHAR_NEWLINE) begin
               cmd.kind = KIND_NEWLINE;
            end else if (char_code == CHAR_BACKSPACE) begin
               cmd.kind = KIND_BACKSPACE;
            end else begin
               cmd.kind = KIND_PUT;
            end
         end
         OP_READ: begin
            // reads past the screen give zero
            cmd.kind = (cell_index < CUR_W'(CELL_TOTAL)) ? KIND_READ : KIND_NOP;
         end
         OP_CLEAR: begin
            cmd.kind = KIND_CLEAR;
         end
         default: begin
            cmd.kind = KIND_NOP;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = status.pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, status.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

[hdl/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// Executes console commands against the screen memory and the cursor, and
// drives the result register.
// ----------------------------------------------------------------------------
module tcw_back
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ATTR_W-1:0]     attr,
   input  logic                  head_valid,
   input  tcw_cmd_type           head_cmd,
   output tcw_status_type        status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata    // cell_data, cursor_pos
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_FILL   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic              fill_clear_ff, fill_clear_in;   // fill after clear, else after scroll
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [CUR_W-1:0]  rsp_cur_ff, rsp_cur_in;

   logic [CELL_W-1:0] mem [CELL_TOTAL];
   logic [CELL_W-1:0] rd_q;
   logic              mem_we, rd_en;
   logic [ADDR_W-1:0] mem_wa, rd_addr;
   logic [CELL_W-1:0] mem_wd;

   logic              out_free;
   logic              pop;
   logic [CUR_W-1:0]  bs_cursor;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign status.pop  = pop;
   assign status.busy = (state_ff == ST_INIT);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {5'd0, rsp_cur_ff, rsp_cell_ff};
   assign bs_cursor   = (cursor_ff != '0) ? cursor_ff - CUR_W'(1) : '0;

   always_comb begin
      state_in      = state_ff;
      fill_clear_in = fill_clear_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      waddr_in      = waddr_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_cur_in    = rsp_cur_ff;
      mem_we        = 1'b0;
      mem_wa        = cnt_ff;
      mem_wd        = CELL_RESET;
      rd_en         = 1'b0;
      rd_addr       = head_cmd.cell_index[ADDR_W-1:0];
      pop           = 1'b0;

      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            if (cnt_ff == ADDR_W'(CELL_TOTAL - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               case (head_cmd.kind)
                  KIND_PUT, KIND_NEWLINE, KIND_BACKSPACE: begin
                     if (cursor_ff == CUR_W'(CELL_TOTAL)) begin
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end else if (out_free) begin
                        pop = 1'b1;
                        if (head_cmd.kind == KIND_NEWLINE) begin
                           cursor_in = CUR_W'(cursor_ff + CUR_W'(COLUMNS) - CUR_W'(col_ff));
                           col_in    = '0;
                        end else if (head_cmd.kind == KIND_BACKSPACE) begin
                           mem_we    = 1'b1;
                           mem_wa    = bs_cursor[ADDR_W-1:0];
                           mem_wd    = {attr, CHAR_SPACE};
                           cursor_in = bs_cursor;
                           if (cursor_ff != '0) begin
                              col_in = (col_ff == '0) ? COL_W'(COLUMNS - 1)
                                                      : col_ff - COL_W'(1);
                           end
                        end else begin
                           mem_we    = 1'b1;
                           mem_wa    = cursor_ff[ADDR_W-1:0];
                           mem_wd    = {attr, head_cmd.char_code};
                           cursor_in = cursor_ff + CUR_W'(1);
                           col_in    = (col_ff == COL_W'(COLUMNS - 1)) ? '0
                                                                        : col_ff + COL_W'(1);
                        end
                        rsp_valid_in = 1'b1;
                        rsp_cell_in  = '0;
                        rsp_cur_in   = cursor_in;
                     end
                  end
                  KIND_READ: begin
                     rd_en    = 1'b1;
                     state_in = ST_EMIT;
                  end
                  KIND_CLEAR: begin
                     cnt_in        = '0;
                     fill_clear_in = 1'b1;
                     state_in      = ST_FILL;
                  end
                  default: begin
                     if (out_free) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_cell_in  = '0;
                        rsp_cur_in   = cursor_ff;
                     end
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            // read one row down, write the cell read in the previous cycle
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(cnt_ff + ADDR_W'(COLUMNS));
            pend_in  = 1'b1;
            waddr_in = cnt_ff;
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = waddr_ff;
               mem_wd = rd_q;
            end
            if (cnt_ff == ADDR_W'(SCROLL_LIM - 1)) begin
               cnt_in        = ADDR_W'(SCROLL_LIM);
               fill_clear_in = 1'b0;
               state_in      = ST_FILL;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (pend_ff) begin
               // last copied cell of a scroll
               mem_wa = waddr_ff;
               mem_wd = rd_q;
            end else begin
               mem_wd = fill_clear_ff ? {attr, CHAR_SPACE} : {attr, CHAR_W'(0)};
               if (cnt_ff == ADDR_W'(CELL_TOTAL - 1)) begin
                  cnt_in = '0;
                  col_in = '0;
                  if (fill_clear_ff) begin
                     cursor_in = '0;
                     state_in  = ST_EMIT;
                  end else begin
                     cursor_in = CUR_W'(SCROLL_LIM);
                     state_in  = ST_IDLE;
                  end
               end else begin
                  cnt_in = cnt_ff + ADDR_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_cell_in  = (head_cmd.kind == KIND_READ) ? rd_q : '0;
               rsp_cur_in   = cursor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         fill_clear_ff <= 1'b0;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         cursor_ff     <= '0;
         col_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_clear_ff <= fill_clear_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         cursor_ff     <= cursor_in;
         col_ff        <= col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      waddr_ff    <= waddr_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_cur_ff  <= rsp_cur_in;
   end

   // screen memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_q <= mem[rd_addr];
      end
   end

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CUR_W'(CELL_TOTAL))
      else $error("cursor beyond end of screen");

   a_home_col: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff == '0) |-> (col_ff == '0))
      else $error("cursor at home but column not zero");

   a_pop_state: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_valid && (state_ff == ST_IDLE || state_ff == ST_EMIT)))
      else $error("command retired outside idle or emit");

   a_busy_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !pop && !rsp_valid_ff)
      else $error("activity during power-up screen fill");

endmodule
